/* hw/rtl/bds_pkg.sv */
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types and constants of the 2x2 box downsampler.
// ----------------------------------------------------------------------------
package bds_pkg;

   // page geometry
   localparam int PAGE_SIDE = 256;
   localparam int HALF_SIZE = PAGE_SIDE / 2;
   localparam int LAST_EVEN = 2 * HALF_SIZE;
   localparam int CNT_W     = $clog2(PAGE_SIDE);
   localparam int SLOT_W    = $clog2(HALF_SIZE);

   // pixel and store layout
   localparam int CHANNELS  = 4;
   localparam int SAMPLE_W  = 8;
   localparam int PAIR_W    = SAMPLE_W + 1;
   localparam int STORE_W   = 10;
   localparam int SUM_W     = STORE_W + 1;
   localparam int COORD_W   = 8;
   localparam int CCOUNT_W  = 3;
   localparam int ROW_W     = CHANNELS * STORE_W;

   localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 3'd4;

   typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] sample_vec_type;
   typedef logic [CHANNELS-1:0][PAIR_W-1:0]   pair_vec_type;
   typedef logic [CHANNELS-1:0][STORE_W-1:0]  store_vec_type;

   // payload of the stage register between front end and averaging stage
   typedef struct packed {
      logic                emit;
      logic [COORD_W-1:0]  target_x;
      logic [COORD_W-1:0]  target_y;
      logic                page_done;
      pair_vec_type        pair;
   } stage_type;

endpackage

/* hw/rtl/bds_ram.sv */
// ----------------------------------------------------------------------------
// bds_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module bds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/bds_front.sv */
// ----------------------------------------------------------------------------
// bds_front
// Raster position counters, left sample register, row store access and the
// stage register that carries each transaction to the averaging stage.
// ----------------------------------------------------------------------------
module bds_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     quadrant,
   input  bds_pkg::sample_vec_type        sample,
   input  logic                           advance,
   output logic                           stage_valid,
   output bds_pkg::stage_type             stage,
   output logic                           store_wr_en,
   output logic [bds_pkg::SLOT_W-1:0]     store_wr_addr,
   output bds_pkg::store_vec_type         store_wr_data,
   output logic                           store_rd_en,
   output logic [bds_pkg::SLOT_W-1:0]     store_rd_addr
);

   logic [bds_pkg::CNT_W-1:0] col_ff, col_in;
   logic [bds_pkg::CNT_W-1:0] row_ff, row_in;
   bds_pkg::sample_vec_type   left_ff, left_in;
   logic                      valid_ff, valid_in;
   bds_pkg::stage_type        stage_ff, stage_in;

   logic                      accept;
   logic                      in_region;
   logic [bds_pkg::SLOT_W-1:0] slot;
   bds_pkg::pair_vec_type     pair;
   logic [bds_pkg::COORD_W-1:0] off_x;
   logic [bds_pkg::COORD_W-1:0] off_y;

   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // position decode
   assign in_region = ({1'b0, col_ff} < (bds_pkg::CNT_W+1)'(bds_pkg::LAST_EVEN)) &&
                      ({1'b0, row_ff} < (bds_pkg::CNT_W+1)'(bds_pkg::LAST_EVEN));
   assign slot      = col_ff[bds_pkg::SLOT_W:1];

   // horizontal pair sums
   always_comb begin
      for (int j = 0; j < bds_pkg::CHANNELS; j++) begin
         pair[j] = bds_pkg::PAIR_W'(left_ff[j]) + bds_pkg::PAIR_W'(sample[j]);
      end
   end

   // row store: write on even rows, read on odd rows
   assign store_wr_en   = accept && in_region && col_ff[0] && !row_ff[0];
   assign store_wr_addr = slot;
   always_comb begin
      for (int j = 0; j < bds_pkg::CHANNELS; j++) begin
         store_wr_data[j] = bds_pkg::STORE_W'(pair[j]);
      end
   end
   assign store_rd_en   = accept && in_region && col_ff[0] && row_ff[0];
   assign store_rd_addr = slot;

   // target placement
   assign off_x = bds_pkg::COORD_W'(bds_pkg::HALF_SIZE) & {bds_pkg::COORD_W{quadrant[0]}};
   assign off_y = bds_pkg::COORD_W'(bds_pkg::HALF_SIZE) & {bds_pkg::COORD_W{quadrant[1]}};

   // next state of counters, left sample and stage register
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      left_in  = left_ff;
      stage_in = stage_ff;
      valid_in = accept || (valid_ff && !advance);
      if (accept) begin
         if (in_region && !col_ff[0]) begin
            left_in = sample;
         end
         if (col_ff == bds_pkg::CNT_W'(bds_pkg::PAGE_SIDE - 1)) begin
            col_in = '0;
            if (row_ff == bds_pkg::CNT_W'(bds_pkg::PAGE_SIDE - 1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
         stage_in.emit      = in_region && col_ff[0] && row_ff[0];
         stage_in.target_x  = off_x + bds_pkg::COORD_W'(slot);
         stage_in.target_y  = off_y + bds_pkg::COORD_W'(row_ff[bds_pkg::CNT_W-1:1]);
         stage_in.page_done =
            (col_ff == bds_pkg::CNT_W'(bds_pkg::LAST_EVEN - 1)) &&
            (row_ff == bds_pkg::CNT_W'(bds_pkg::LAST_EVEN - 1));
         stage_in.pair      = pair;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         left_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         left_ff  <= left_in;
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

/* hw/rtl/bds_avg.sv */
// ----------------------------------------------------------------------------
// bds_avg
// Completes the 2x2 sums, divides by four, masks unused channels and holds
// the result in the output register.
// ----------------------------------------------------------------------------
module bds_avg (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              stage_valid,
   input  bds_pkg::stage_type                stage,
   input  bds_pkg::store_vec_type            stored,
   input  logic [bds_pkg::CCOUNT_W-1:0]      channel_count,
   output logic                              advance,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bds_pkg::COORD_W-1:0]       target_x,
   output logic [bds_pkg::COORD_W-1:0]       target_y,
   output bds_pkg::sample_vec_type           chan_out,
   output logic                              page_done
);

   logic                              valid_ff, valid_in;
   logic [bds_pkg::COORD_W-1:0]       x_ff, y_ff;
   bds_pkg::sample_vec_type           chan_ff, avg;
   logic                              done_ff;
   logic                              load;
   logic [bds_pkg::SUM_W-1:0]         total;

   assign advance = !valid_ff || !rsp_stall;
   assign load    = advance && stage_valid && stage.emit;

   // four-sample average per channel, unused channels read 0
   always_comb begin
      total = '0;
      for (int j = 0; j < bds_pkg::CHANNELS; j++) begin
         total  = bds_pkg::SUM_W'(stored[j]) + bds_pkg::SUM_W'(stage.pair[j]);
         avg[j] = (channel_count > bds_pkg::CCOUNT_W'(j)) ?
                  total[bds_pkg::SAMPLE_W+1:2] : '0;
      end
   end

   // output valid
   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         x_ff    <= stage.target_x;
         y_ff    <= stage.target_y;
         chan_ff <= avg;
         done_ff <= stage.page_done;
      end
   end

   assign rsp_valid = valid_ff;
   assign target_x  = x_ff;
   assign target_y  = y_ff;
   assign chan_out  = chan_ff;
   assign page_done = done_ff;

endmodule

/* hw/rtl/box_downsample_2x2_top.sv */
// ----------------------------------------------------------------------------
// box_downsample_2x2_top
// 2x2 box downsampler: one averaged pixel per 2x2 block of a square page.
// ----------------------------------------------------------------------------
// Usage:
//   Source pixels of a 256x256 page enter in raster order on the req_
//   channel (valid/stall); each transaction carries four 8-bit samples and
//   the target quadrant. The pixel that closes a 2x2 block (odd column, odd
//   row) produces one rsp_ transaction with the target coordinates, the four
//   floor averages and page_done on the last block of the page. Other pixels
//   produce nothing.
//   From an accepted pixel to rsp_valid the result passes the stage register
//   (with the row store read), then the output register.
//   Throughput: one pixel per cycle unless rsp_stall holds it; the row store
//   has one write and one read port.
//   The csr_ channel is always ready; the user must write channel_count only
//   while the block is idle (unenforced). Channels at or above it read 0.
//   Reset clears the raster position, the left sample, all valid flags and
//   sets channel_count to 4. The row store needs no clearing: every entry is
//   written on an even row before an odd row reads it.
//   While rsp_stall is high the result is held; one more pixel may enter the
//   stage register, after which req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module box_downsample_2x2_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bds_pkg::CCOUNT_W-1:0]   csr_channel_count,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_quadrant,
   input  logic [7:0]                     req_chan0_in,
   input  logic [7:0]                     req_chan1_in,
   input  logic [7:0]                     req_chan2_in,
   input  logic [7:0]                     req_chan3_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_target_x,
   output logic [7:0]                     rsp_target_y,
   output logic [7:0]                     rsp_chan0_out,
   output logic [7:0]                     rsp_chan1_out,
   output logic [7:0]                     rsp_chan2_out,
   output logic [7:0]                     rsp_chan3_out,
   output logic                           rsp_page_done
);

   logic [bds_pkg::CCOUNT_W-1:0]  ccount_ff, ccount_in;
   bds_pkg::sample_vec_type       sample;
   bds_pkg::sample_vec_type       chan_out;
   logic                          advance;
   logic                          stage_valid;
   bds_pkg::stage_type            stage;
   logic                          store_wr_en;
   logic [bds_pkg::SLOT_W-1:0]    store_wr_addr;
   bds_pkg::store_vec_type        store_wr_data;
   logic                          store_rd_en;
   logic [bds_pkg::SLOT_W-1:0]    store_rd_addr;
   logic [bds_pkg::ROW_W-1:0]     store_rd_data;

   // channel count register
   assign csr_ready = 1'b1;
   always_comb begin
      ccount_in = ccount_ff;
      if (csr_valid && csr_ready) begin
         ccount_in = csr_channel_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ccount_ff <= bds_pkg::CCOUNT_RESET;
      end else begin
         ccount_ff <= ccount_in;
      end
   end

   // sample gathering
   assign sample[0] = req_chan0_in;
   assign sample[1] = req_chan1_in;
   assign sample[2] = req_chan2_in;
   assign sample[3] = req_chan3_in;

   // position tracking and row store access
   bds_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .quadrant      (req_quadrant),
      .sample        (sample),
      .advance       (advance),
      .stage_valid   (stage_valid),
      .stage         (stage),
      .store_wr_en   (store_wr_en),
      .store_wr_addr (store_wr_addr),
      .store_wr_data (store_wr_data),
      .store_rd_en   (store_rd_en),
      .store_rd_addr (store_rd_addr)
   );

   // row store of horizontal pair sums
   bds_ram #(
      .WIDTH (bds_pkg::ROW_W),
      .DEPTH (bds_pkg::HALF_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (store_wr_addr),
      .wr_data (store_wr_data),
      .rd_en   (store_rd_en),
      .rd_addr (store_rd_addr),
      .rd_data (store_rd_data)
   );

   // averaging and output register
   bds_avg u_avg (
      .clock         (clock),
      .reset         (reset),
      .stage_valid   (stage_valid),
      .stage         (stage),
      .stored        (bds_pkg::store_vec_type'(store_rd_data)),
      .channel_count (ccount_ff),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .target_x      (rsp_target_x),
      .target_y      (rsp_target_y),
      .chan_out      (chan_out),
      .page_done     (rsp_page_done)
   );

   assign rsp_chan0_out = chan_out[0];
   assign rsp_chan1_out = chan_out[1];
   assign rsp_chan2_out = chan_out[2];
   assign rsp_chan3_out = chan_out[3];

endmodule
